// File: hw/rtl/chs_pkg.sv
`timescale 1ns / 1ps
// Shared widths, constants, types and pass tables for the CHS geometry search.
// No dependencies; used by chs_serial_divider and chs_geometry_search_unit.
package chs_pkg;

   localparam int CAP_W  = 48;
   localparam int CYL_W  = 16;
   localparam int HEAD_W = 5;
   localparam int SECT_W = 6;
   localparam int TIER_W = 2;

   localparam int MAX_HEADS   = 16;
   localparam int MAX_SECTORS = 63;

   localparam int SCNT_W = $clog2(MAX_SECTORS + 1);
   localparam int TRK_W  = $clog2(MAX_HEADS * MAX_SECTORS + 1);
   localparam int DCNT_W = $clog2(CAP_W);

   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_SMALL_LIMIT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_LARGE_LIMIT = 1'b1;

   localparam logic [CAP_W-1:0] SMALL_LIMIT_RESET = 48'd1032192;
   localparam logic [CAP_W-1:0] LARGE_LIMIT_RESET = 48'd16514064;

   localparam logic [TIER_W-1:0] TIER_SMALL = 2'd0;
   localparam logic [TIER_W-1:0] TIER_MULTI = 2'd1;
   localparam logic [TIER_W-1:0] TIER_FIXED = 2'd2;

   localparam logic [CYL_W-1:0]  FIXED_CYL   = 16'd16383;
   localparam logic [HEAD_W-1:0] FIXED_HEADS = 5'd16;
   localparam logic [SECT_W-1:0] FIXED_SECT  = 6'd63;

   typedef enum logic [1:0] {
      PASS_SMALL,
      PASS_CYL16K,
      PASS_CYL32K,
      PASS_CYL64K
   } pass_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_START,
      ST_WAIT,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic             exact;
      logic [CAP_W-1:0] quotient;
   } div_status_type;

   function automatic logic [CYL_W-1:0] pass_cyl_max(input pass_type p);
      logic [CYL_W-1:0] m;
      unique case (p)
         PASS_SMALL:  m = 16'd1024;
         PASS_CYL16K: m = 16'd16383;
         PASS_CYL32K: m = 16'd32767;
         PASS_CYL64K: m = 16'd65535;
         default:     m = 16'd0;
      endcase
      return m;
   endfunction

   function automatic logic [HEAD_W-1:0] pass_head_floor(input pass_type p);
      logic [HEAD_W-1:0] m;
      unique case (p)
         PASS_SMALL:  m = 5'd1;
         PASS_CYL16K: m = 5'd9;
         PASS_CYL32K: m = 5'd5;
         PASS_CYL64K: m = 5'd1;
         default:     m = 5'd1;
      endcase
      return m;
   endfunction

endpackage

// File: hw/rtl/chs_serial_divider.sv
`timescale 1ns / 1ps
// Bit-serial restoring divider: 48-bit dividend by a narrow track size.
// One quotient bit per cycle; depends on chs_pkg.
module chs_serial_divider (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [chs_pkg::CAP_W-1:0]   dividend,
   input  logic [chs_pkg::TRK_W-1:0]   divisor,
   output chs_pkg::div_status_type     status
);

   logic                         busy_ff, busy_in;
   logic                         done_ff, done_in;
   logic [chs_pkg::DCNT_W-1:0]   cnt_ff, cnt_in;
   logic [chs_pkg::CAP_W-1:0]    dvd_ff, dvd_in;
   logic [chs_pkg::TRK_W-1:0]    rem_ff, rem_in;
   logic [chs_pkg::TRK_W-1:0]    dsr_ff, dsr_in;
   logic [chs_pkg::TRK_W:0]      trial;
   logic [chs_pkg::TRK_W:0]      diff;
   logic                         ge;

   always_comb begin
      trial = {rem_ff, dvd_ff[chs_pkg::CAP_W-1]};
      diff  = trial - {1'b0, dsr_ff};
      ge    = (trial >= {1'b0, dsr_ff});
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         dvd_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = chs_pkg::DCNT_W'(chs_pkg::CAP_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[chs_pkg::CAP_W-2:0], ge};
         rem_in = ge ? diff[chs_pkg::TRK_W-1:0] : trial[chs_pkg::TRK_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign status.busy     = busy_ff;
   assign status.done     = done_ff;
   assign status.exact    = (rem_ff == '0);
   assign status.quotient = dvd_ff;

endmodule

// File: hw/rtl/chs_geometry_search_unit.sv
`timescale 1ns / 1ps
// Search: the fixed tier needs no trial; otherwise the divider runs one division per
// heads/sectors trial, and the search moves to the next pass when one is exhausted:
// at most 1008 trials in the small tier, 2268 over the three passes.
// Throughput: one request at a time; the next is taken the cycle after the result is
// registered, while that result may still wait in the output register.
// Reset: synchronous, clears control and loads the default tier limits. Needs chs_pkg, divider.
module chs_geometry_search_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [chs_pkg::CAP_W-1:0]       req_capacity_sectors,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [chs_pkg::CYL_W-1:0]       rsp_cylinder_count,
   output logic [chs_pkg::HEAD_W-1:0]      rsp_head_count,
   output logic [chs_pkg::SECT_W-1:0]      rsp_sectors_per_track,
   output logic                            rsp_geometry_valid,
   output logic [chs_pkg::TIER_W-1:0]      rsp_tier_used,
   input  logic                            csr_write_enable,
   input  logic [chs_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [chs_pkg::CAP_W-1:0]       csr_write_data
);

   chs_pkg::state_type              state_ff, state_in;
   chs_pkg::pass_type               pass_ff, pass_in;
   logic [chs_pkg::CAP_W-1:0]       small_lim_ff, small_lim_in;
   logic [chs_pkg::CAP_W-1:0]       large_lim_ff, large_lim_in;
   logic [chs_pkg::CAP_W-1:0]       cap_ff, cap_in;
   logic [chs_pkg::HEAD_W-1:0]      h_ff, h_in;
   logic [chs_pkg::SCNT_W-1:0]      s_ff, s_in;
   logic [chs_pkg::CYL_W-1:0]       res_cyl_ff, res_cyl_in;
   logic [chs_pkg::HEAD_W-1:0]      res_head_ff, res_head_in;
   logic [chs_pkg::SECT_W-1:0]      res_sec_ff, res_sec_in;
   logic                            res_found_ff, res_found_in;
   logic [chs_pkg::TIER_W-1:0]      tier_ff, tier_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [chs_pkg::CYL_W-1:0]       rsp_cyl_ff, rsp_cyl_in;
   logic [chs_pkg::HEAD_W-1:0]      rsp_head_ff, rsp_head_in;
   logic [chs_pkg::SECT_W-1:0]      rsp_sec_ff, rsp_sec_in;
   logic                            rsp_found_ff, rsp_found_in;
   logic [chs_pkg::TIER_W-1:0]      rsp_tier_ff, rsp_tier_in;

   logic                            div_start;
   logic [chs_pkg::TRK_W-1:0]       track;
   chs_pkg::div_status_type         div_st;
   logic                            q_fits;
   logic [chs_pkg::SCNT_W+chs_pkg::SECT_W-1:0] sec_wide;

   assign track    = chs_pkg::TRK_W'(32'(h_ff) * 32'(s_ff));
   assign sec_wide = {chs_pkg::SECT_W'(0), s_ff};
   assign q_fits   = (div_st.quotient[chs_pkg::CAP_W-1:chs_pkg::CYL_W] == '0) &&
                     (div_st.quotient[chs_pkg::CYL_W-1:0] <= chs_pkg::pass_cyl_max(pass_ff));

   chs_serial_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (cap_ff),
      .divisor  (track),
      .status   (div_st)
   );

   // configuration
   always_comb begin
      small_lim_in = small_lim_ff;
      large_lim_in = large_lim_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            chs_pkg::CSR_SMALL_LIMIT: small_lim_in = csr_write_data;
            chs_pkg::CSR_LARGE_LIMIT: large_lim_in = csr_write_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      pass_in      = pass_ff;
      cap_in       = cap_ff;
      h_in         = h_ff;
      s_in         = s_ff;
      res_cyl_in   = res_cyl_ff;
      res_head_in  = res_head_ff;
      res_sec_in   = res_sec_ff;
      res_found_in = res_found_ff;
      tier_in      = tier_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_cyl_in   = rsp_cyl_ff;
      rsp_head_in  = rsp_head_ff;
      rsp_sec_in   = rsp_sec_ff;
      rsp_found_in = rsp_found_ff;
      rsp_tier_in  = rsp_tier_ff;
      div_start    = 1'b0;
      req_ready    = (state_ff == chs_pkg::ST_IDLE);
      unique case (state_ff)
         chs_pkg::ST_IDLE: begin
            if (req_valid) begin
               cap_in       = req_capacity_sectors;
               h_in         = chs_pkg::HEAD_W'(chs_pkg::MAX_HEADS);
               s_in         = chs_pkg::SCNT_W'(chs_pkg::MAX_SECTORS);
               res_cyl_in   = '0;
               res_head_in  = '0;
               res_sec_in   = '0;
               res_found_in = 1'b0;
               if (req_capacity_sectors <= small_lim_ff) begin
                  tier_in  = chs_pkg::TIER_SMALL;
                  pass_in  = chs_pkg::PASS_SMALL;
                  state_in = chs_pkg::ST_START;
               end else if (req_capacity_sectors <= large_lim_ff) begin
                  tier_in  = chs_pkg::TIER_MULTI;
                  pass_in  = chs_pkg::PASS_CYL16K;
                  state_in = chs_pkg::ST_START;
               end else begin
                  tier_in      = chs_pkg::TIER_FIXED;
                  res_cyl_in   = chs_pkg::FIXED_CYL;
                  res_head_in  = chs_pkg::FIXED_HEADS;
                  res_sec_in   = chs_pkg::FIXED_SECT;
                  res_found_in = 1'b1;
                  state_in     = chs_pkg::ST_FINISH;
               end
            end
         end
         chs_pkg::ST_START: begin
            if (h_ff < chs_pkg::pass_head_floor(pass_ff)) begin
               // pass exhausted: advance to the next one or give up
               h_in = chs_pkg::HEAD_W'(chs_pkg::MAX_HEADS);
               s_in = chs_pkg::SCNT_W'(chs_pkg::MAX_SECTORS);
               unique case (pass_ff)
                  chs_pkg::PASS_CYL16K: pass_in = chs_pkg::PASS_CYL32K;
                  chs_pkg::PASS_CYL32K: pass_in = chs_pkg::PASS_CYL64K;
                  default:              state_in = chs_pkg::ST_FINISH;
               endcase
            end else begin
               div_start = 1'b1;
               state_in  = chs_pkg::ST_WAIT;
            end
         end
         chs_pkg::ST_WAIT: begin
            if (div_st.done) begin
               if (div_st.exact && q_fits) begin
                  res_cyl_in   = div_st.quotient[chs_pkg::CYL_W-1:0];
                  res_head_in  = h_ff;
                  res_sec_in   = sec_wide[chs_pkg::SECT_W-1:0];
                  res_found_in = 1'b1;
                  state_in     = chs_pkg::ST_FINISH;
               end else begin
                  if (s_ff == chs_pkg::SCNT_W'(1)) begin
                     s_in = chs_pkg::SCNT_W'(chs_pkg::MAX_SECTORS);
                     h_in = h_ff - 1'b1;
                  end else begin
                     s_in = s_ff - 1'b1;
                  end
                  state_in = chs_pkg::ST_START;
               end
            end
         end
         chs_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_cyl_in   = res_cyl_ff;
               rsp_head_in  = res_head_ff;
               rsp_sec_in   = res_sec_ff;
               rsp_found_in = res_found_ff;
               rsp_tier_in  = tier_ff;
               state_in     = chs_pkg::ST_IDLE;
            end
         end
         default: state_in = chs_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= chs_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         small_lim_ff <= chs_pkg::SMALL_LIMIT_RESET;
         large_lim_ff <= chs_pkg::LARGE_LIMIT_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         small_lim_ff <= small_lim_in;
         large_lim_ff <= large_lim_in;
      end
      pass_ff      <= pass_in;
      cap_ff       <= cap_in;
      h_ff         <= h_in;
      s_ff         <= s_in;
      res_cyl_ff   <= res_cyl_in;
      res_head_ff  <= res_head_in;
      res_sec_ff   <= res_sec_in;
      res_found_ff <= res_found_in;
      tier_ff      <= tier_in;
      rsp_cyl_ff   <= rsp_cyl_in;
      rsp_head_ff  <= rsp_head_in;
      rsp_sec_ff   <= rsp_sec_in;
      rsp_found_ff <= rsp_found_in;
      rsp_tier_ff  <= rsp_tier_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_cylinder_count    = rsp_cyl_ff;
   assign rsp_head_count        = rsp_head_ff;
   assign rsp_sectors_per_track = rsp_sec_ff;
   assign rsp_geometry_valid    = rsp_found_ff;
   assign rsp_tier_used         = rsp_tier_ff;

   a_not_found_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_found_ff |->
         rsp_cyl_ff == '0 && rsp_head_ff == '0 && rsp_sec_ff == '0)
      else $error("unfound geometry with nonzero fields");

   a_fixed_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_tier_ff == chs_pkg::TIER_FIXED |-> rsp_found_ff)
      else $error("fixed tier without valid geometry");

   a_start_idle_div: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_st.busy && !div_st.done)
      else $error("divider started while busy");

   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_st.done |-> state_ff == chs_pkg::ST_WAIT)
      else $error("divider result outside wait");

   a_trial_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == chs_pkg::ST_WAIT |-> h_ff != '0 && s_ff != '0)
      else $error("zero heads or sectors in trial");

endmodule
